@@ design/segment_reorder_and_ack_assert.svh @@
// assertion macros shared by the segment reorder block
// depends on: a clock named clk and a synchronous reset named rst in the using module
`ifndef SEGMENT_REORDER_AND_ACK_ASSERT_SVH
`define SEGMENT_REORDER_AND_ACK_ASSERT_SVH

// same-cycle implication
`define SRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sra_pkg.sv @@
// shared types and constants of the segment reorder and ack block
// no dependencies
package sra_pkg;

  localparam int SEQ_W            = 31;
  localparam int LEN_W            = 12;
  localparam int SLOT_W           = 5;
  localparam int WINDOW_SLOTS_DEF = 32;

  localparam logic [LEN_W-1:0] SEGMENT_BYTES_RESET = 12'd1456;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_DECIDE,
    ST_READ,
    ST_RELEASE,
    ST_ACK
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic mark_done;
    logic div_start;
    logic store_early;
    logic store_head;
    logic rd_slot;
    logic emit_release;
    logic emit_ack;
  } ctrl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic done;
    logic div_busy;
    logic seq_gt;
    logic seq_lt;
    logic cur_valid;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/sra_div.sv @@
// two-lane restoring divider, one quotient bit per cycle, also gives quotient mod window
// depends on: sra_pkg
module sra_div #(
  parameter int WINDOW_SLOTS = sra_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [sra_pkg::LEN_W-1:0]             divisor,
  input  logic [sra_pkg::SEQ_W-1:0]             dividend_a,
  input  logic [sra_pkg::SEQ_W-1:0]             dividend_b,
  output logic                                  busy,
  output logic [sra_pkg::SEQ_W-1:0]             quo_a,
  output logic [sra_pkg::SEQ_W-1:0]             quo_b,
  output logic [$clog2(WINDOW_SLOTS)-1:0]       mod_a,
  output logic [$clog2(WINDOW_SLOTS)-1:0]       mod_b
);
  import sra_pkg::*;

  localparam int SLOT_AW = $clog2(WINDOW_SLOTS);
  localparam int CNT_W   = $clog2(SEQ_W);

  logic [CNT_W-1:0]   cnt;
  logic [LEN_W-1:0]   div_reg;
  logic [SEQ_W-1:0]   dvd [2];
  logic [SEQ_W-1:0]   quo [2];
  logic [LEN_W-1:0]   rem [2];
  logic [SLOT_AW-1:0] qm  [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SEQ_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_reg <= divisor;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [LEN_W:0]     rem_sh;
    logic               ge;
    logic [LEN_W:0]     rem_sub;
    logic [SLOT_AW:0]   qm_sh;
    logic [SLOT_AW:0]   qm_sub;

    always_comb begin
      rem_sh  = {rem[g], dvd[g][SEQ_W-1]};
      ge      = rem_sh >= {1'b0, div_reg};
      rem_sub = rem_sh - {1'b0, div_reg};
      qm_sh   = {qm[g], ge};
      qm_sub  = qm_sh - (SLOT_AW + 1)'(WINDOW_SLOTS);
    end

    always_ff @(posedge clk) begin
      if (start) begin
        dvd[g] <= (g == 0) ? dividend_a : dividend_b;
        quo[g] <= '0;
        rem[g] <= '0;
        qm[g]  <= '0;
      end else if (busy) begin
        dvd[g] <= {dvd[g][SEQ_W-2:0], 1'b0};
        quo[g] <= {quo[g][SEQ_W-2:0], ge};
        rem[g] <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        qm[g]  <= (qm_sh >= (SLOT_AW + 1)'(WINDOW_SLOTS)) ? qm_sub[SLOT_AW-1:0]
                                                          : qm_sh[SLOT_AW-1:0];
      end
    end
  end

  assign quo_a = quo[0];
  assign quo_b = quo[1];
  assign mod_a = qm[0];
  assign mod_b = qm[1];

endmodule

@@ design/sra_datapath.sv @@
// datapath: item registers, segment size register, slot store, divider, result register
// depends on: sra_pkg, sra_div, segment_reorder_and_ack_assert.svh
`include "segment_reorder_and_ack_assert.svh"
module sra_datapath #(
  parameter int WINDOW_SLOTS = sra_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sra_pkg::ctrl_cmd_t            cmd,
  output sra_pkg::dp_status_t           status,
  input  logic                          cfg_we,
  input  logic [sra_pkg::LEN_W-1:0]     segment_bytes,
  input  logic [sra_pkg::SEQ_W-1:0]     seq_number,
  input  logic [sra_pkg::LEN_W-1:0]     payload_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [sra_pkg::SLOT_W-1:0]    slot_index,
  output logic [sra_pkg::SEQ_W-1:0]     byte_offset,
  output logic [sra_pkg::LEN_W-1:0]     release_length,
  output logic [sra_pkg::SEQ_W-1:0]     ack_number,
  output logic                          end_of_transfer,
  output logic                          last_result
);
  import sra_pkg::*;

  localparam int SLOT_AW = $clog2(WINDOW_SLOTS);

  logic [LEN_W-1:0]        seg_bytes;
  logic [LEN_W-1:0]        divisor;
  logic [SEQ_W-1:0]        item_seq;
  logic [LEN_W-1:0]        item_len;
  logic [SEQ_W-1:0]        expected;
  logic                    done;
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [SLOT_AW-1:0]      cur_s;
  logic [LEN_W-1:0]        len_mem [WINDOW_SLOTS];
  logic [LEN_W-1:0]        rd_len;
  logic                    div_busy;
  logic [SEQ_W-1:0]        q_idx;
  logic [SEQ_W-1:0]        q_head;
  logic [SLOT_AW-1:0]      idx_mod;
  logic [SLOT_AW-1:0]      head_mod;
  logic [SEQ_W-1:0]        slot_gap;
  logic                    early_ok;
  logic                    mem_we;
  logic [SLOT_AW-1:0]      mem_waddr;
  logic                    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_bytes <= SEGMENT_BYTES_RESET;
    end else if (cfg_we) begin
      seg_bytes <= segment_bytes;
    end
  end

  assign divisor = (seg_bytes == '0) ? LEN_W'(1) : seg_bytes;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_seq <= seq_number;
      item_len <= payload_bytes;
    end
  end

  sra_div #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .divisor    (divisor),
    .dividend_a (item_seq),
    .dividend_b (expected),
    .busy       (div_busy),
    .quo_a      (q_idx),
    .quo_b      (q_head),
    .mod_a      (idx_mod),
    .mod_b      (head_mod)
  );

  // early segment goes in only 1 to window-1 slots past the head, into an empty slot
  always_comb begin
    slot_gap = q_idx - q_head;
    early_ok = (q_idx >= q_head) && (slot_gap != '0) && (slot_gap < SEQ_W'(WINDOW_SLOTS))
               && !slot_valid[idx_mod];
    mem_we    = cmd.store_head || (cmd.store_early && early_ok);
    mem_waddr = cmd.store_head ? head_mod : idx_mod;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      len_mem[mem_waddr] <= item_len;
    end
    if (cmd.rd_slot) begin
      rd_len <= len_mem[cur_s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected   <= '0;
      done       <= 1'b0;
      slot_valid <= '0;
      cur_s      <= '0;
    end else begin
      if (cmd.mark_done) begin
        done <= 1'b1;
      end
      if (mem_we) begin
        slot_valid[mem_waddr] <= 1'b1;
      end
      if (cmd.store_head) begin
        cur_s <= head_mod;
      end
      if (cmd.emit_release) begin
        expected          <= expected + SEQ_W'(rd_len);
        slot_valid[cur_s] <= 1'b0;
        cur_s <= (cur_s == SLOT_AW'(WINDOW_SLOTS - 1)) ? '0 : cur_s + 1'b1;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_release || cmd.emit_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_release) begin
      kind            <= KIND_RELEASE;
      slot_index      <= SLOT_W'(cur_s);
      byte_offset     <= expected;
      release_length  <= rd_len;
      ack_number      <= '0;
      end_of_transfer <= 1'b0;
      last_result     <= 1'b0;
    end else if (cmd.emit_ack) begin
      kind            <= KIND_ACK;
      slot_index      <= '0;
      byte_offset     <= '0;
      release_length  <= '0;
      ack_number      <= (item_len == '0) ? item_seq : expected;
      end_of_transfer <= done;
      last_result     <= 1'b1;
    end
  end

  always_comb begin
    status.len_zero  = item_len == '0;
    status.done      = done;
    status.div_busy  = div_busy;
    status.seq_gt    = item_seq > expected;
    status.seq_lt    = item_seq < expected;
    status.cur_valid = slot_valid[cur_s];
    status.out_free  = out_free;
  end

  `SRA_ASSERT_IMPL(a_read_valid_slot, cmd.rd_slot, slot_valid[cur_s], "read of empty slot")
  `SRA_ASSERT_IMPL(a_load_when_free, cmd.emit_release || cmd.emit_ack, out_free, "result overwritten")
  `SRA_ASSERT_IMPL(a_div_idle_start, cmd.div_start, !div_busy, "divider restarted while busy")
  `SRA_ASSERT_NEXT(a_div_runs, cmd.div_start, div_busy, "divider did not start")
  `SRA_ASSERT_NEXT(a_slot_cleared, cmd.emit_release, !slot_valid[$past(cur_s)], "slot still valid")

endmodule

@@ design/sra_ctrl.sv @@
// controller state machine: classify, divide, store, drain, acknowledge
// depends on: sra_pkg
module sra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sra_pkg::dp_status_t  status,
  output sra_pkg::ctrl_cmd_t   cmd
);
  import sra_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status.len_zero || status.done) begin
          state_next = ST_ACK;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!status.div_busy) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.seq_gt || status.seq_lt) begin
          state_next = ST_ACK;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = status.cur_valid ? ST_RELEASE : ST_ACK;
      end
      ST_RELEASE: begin
        if (status.out_free) begin
          state_next = ST_READ;
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall      = rst;
        cmd.load_item = in_valid && !rst;
      end
      ST_CLASSIFY: begin
        cmd.mark_done = status.len_zero;
        cmd.div_start = !status.len_zero && !status.done;
      end
      ST_DECIDE: begin
        cmd.store_early = status.seq_gt;
        cmd.store_head  = !status.seq_gt && !status.seq_lt;
      end
      ST_READ: begin
        cmd.rd_slot = status.cur_valid;
      end
      ST_RELEASE: begin
        cmd.emit_release = status.out_free;
      end
      ST_ACK: begin
        cmd.emit_ack = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/segment_reorder_and_ack.sv @@
// segment reorder and cumulative ack; depends on sra_pkg, sra_ctrl, sra_datapath
// end segment or after the end: ack straight from classify, no divide; next request after the ack
// duplicate or early: ack after the divide, next request after the ack; the shared
// divider (seq and expected divided by segment size together) sets this
// in order: slots from the head on are released while valid, then the ack; out_stall holds results
// rst (synchronous) clears window valid bits, expected seq, end flag; segment size to 1456
module segment_reorder_and_ack #(
  parameter int WINDOW_SLOTS = sra_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sra_pkg::LEN_W-1:0]     segment_bytes,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sra_pkg::SEQ_W-1:0]     seq_number,
  input  logic [sra_pkg::LEN_W-1:0]     payload_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [sra_pkg::SLOT_W-1:0]    slot_index,
  output logic [sra_pkg::SEQ_W-1:0]     byte_offset,
  output logic [sra_pkg::LEN_W-1:0]     release_length,
  output logic [sra_pkg::SEQ_W-1:0]     ack_number,
  output logic                          end_of_transfer,
  output logic                          last_result
);
  import sra_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = !rst;

  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sra_datapath #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid && cfg_ready),
    .segment_bytes   (segment_bytes),
    .seq_number      (seq_number),
    .payload_bytes   (payload_bytes),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .slot_index      (slot_index),
    .byte_offset     (byte_offset),
    .release_length  (release_length),
    .ack_number      (ack_number),
    .end_of_transfer (end_of_transfer),
    .last_result     (last_result)
  );

endmodule
